### hdl/pzm_pkg.sv
package pzm_pkg;

	// Configuration register map
	localparam int CFG_IDX_BITS = 2;
	localparam int TOL_BITS     = 20;
	localparam logic [CFG_IDX_BITS-1:0] REG_AREA_TOL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZONES    = 2'd1;
	localparam logic [TOL_BITS-1:0]     AREA_TOL_RESET = 20'd66;

	// Result item width on the master side
	localparam int OUT_BITS = 8;

	// Per-item control that travels down the pipeline
	typedef struct packed {
		logic first;      // first vertex of a polygon: sums restart
		logic close;      // last vertex of a polygon: closing edge and test
		logic eos;        // last vertex of the set: emit a result
		logic set_start;  // first vertex of a set: clear the match flag
	} pzm_flags_t;

	// Live configuration
	typedef struct packed {
		logic [TOL_BITS-1:0] area_tol;
		logic                zones_defined;
	} pzm_cfg_t;

endpackage

### hdl/pzm_front.sv
module pzm_front #(
	parameter int CB = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [CB-1:0]   query_x,
	input  logic signed [CB-1:0]   query_y,
	input  logic signed [CB-1:0]   vertex_x,
	input  logic signed [CB-1:0]   vertex_y,
	input  logic                   end_of_polygon,
	input  logic                   end_of_set,
	input  logic                   down_ready,
	output logic                   valid_s1,
	output pzm_pkg::pzm_flags_t    flags_s1,
	output logic signed [CB-1:0]   vert_x_s1,
	output logic signed [CB-1:0]   vert_y_s1,
	output logic signed [CB-1:0]   prior_x_s1,
	output logic signed [CB-1:0]   prior_y_s1,
	output logic signed [CB-1:0]   start_x_s1,
	output logic signed [CB-1:0]   start_y_s1,
	output logic signed [CB-1:0]   point_x_s1,
	output logic signed [CB-1:0]   point_y_s1
);
	import pzm_pkg::*;

	logic                 at_set_q;
	logic                 at_poly_q;
	logic signed [CB-1:0] held_x_q, held_y_q;
	logic signed [CB-1:0] start_x_q, start_y_q;
	logic signed [CB-1:0] prior_x_q, prior_y_q;
	logic                 accept;
	logic                 closing;

	assign in_ready = !valid_s1 || down_ready;
	assign accept   = in_valid && in_ready;
	assign closing  = end_of_polygon || end_of_set;

	// Track set and polygon boundaries, advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			at_set_q  <= 1'b1;
			at_poly_q <= 1'b1;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				at_set_q  <= end_of_set;
				at_poly_q <= closing;
			end
		end
	end

	// Latch query point, first and prior vertex; load the item into stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			if (at_set_q) begin
				held_x_q <= query_x;
				held_y_q <= query_y;
			end
			if (at_poly_q) begin
				start_x_q <= vertex_x;
				start_y_q <= vertex_y;
			end
			prior_x_q <= vertex_x;
			prior_y_q <= vertex_y;

			vert_x_s1  <= vertex_x;
			vert_y_s1  <= vertex_y;
			prior_x_s1 <= prior_x_q;
			prior_y_s1 <= prior_y_q;
			start_x_s1 <= at_poly_q ? vertex_x : start_x_q;
			start_y_s1 <= at_poly_q ? vertex_y : start_y_q;
			point_x_s1 <= at_set_q ? query_x : held_x_q;
			point_y_s1 <= at_set_q ? query_y : held_y_q;
			flags_s1.first     <= at_poly_q;
			flags_s1.close     <= closing;
			flags_s1.eos       <= end_of_set;
			flags_s1.set_start <= at_set_q;
		end
	end

	// A closing item restarts the polygon, a set end restarts the set
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && closing) |=> at_poly_q)
		else $error("polygon start not armed after closing item");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !end_of_set) |=> !at_set_q)
		else $error("set start armed without set end");

endmodule

### hdl/pzm_cross.sv
module pzm_cross #(
	parameter int CB = 24,
	parameter int TW = 2 * CB + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	output logic                 up_ready,
	input  pzm_pkg::pzm_flags_t  flags_s1,
	input  logic signed [CB-1:0] vert_x_s1,
	input  logic signed [CB-1:0] vert_y_s1,
	input  logic signed [CB-1:0] prior_x_s1,
	input  logic signed [CB-1:0] prior_y_s1,
	input  logic signed [CB-1:0] start_x_s1,
	input  logic signed [CB-1:0] start_y_s1,
	input  logic signed [CB-1:0] point_x_s1,
	input  logic signed [CB-1:0] point_y_s1,
	input  logic                 down_ready,
	output logic                 valid_s3,
	output pzm_pkg::pzm_flags_t  flags_s3,
	output logic signed [TW-1:0] shoe_a_s3,
	output logic signed [TW-1:0] tri_a_s3,
	output logic signed [TW-1:0] shoe_b_s3,
	output logic signed [TW-1:0] tri_b_s3
);
	import pzm_pkg::*;

	localparam int DW = CB + 1;
	localparam int SPW = 2 * CB;
	localparam int TPW = 2 * DW;

	logic valid_s2;
	logic ready_s2, ready_s3;
	pzm_flags_t flags_s2;

	// Edge a runs (vertex, prior), edge b runs (start, vertex)
	logic signed [DW-1:0] dvx, dvy, dpx, dpy, dsx, dsy;
	logic signed [SPW-1:0] sa0_s2, sa1_s2, sb0_s2, sb1_s2;
	logic signed [TPW-1:0] ta0_s2, ta1_s2, tb0_s2, tb1_s2;
	logic signed [TW-1:0] shoe_a, shoe_b, tri_ad, tri_bd;

	assign ready_s3 = !valid_s3 || down_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	// Offsets from the query point
	assign dvx = DW'(vert_x_s1)  - DW'(point_x_s1);
	assign dvy = DW'(vert_y_s1)  - DW'(point_y_s1);
	assign dpx = DW'(prior_x_s1) - DW'(point_x_s1);
	assign dpy = DW'(prior_y_s1) - DW'(point_y_s1);
	assign dsx = DW'(start_x_s1) - DW'(point_x_s1);
	assign dsy = DW'(start_y_s1) - DW'(point_y_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 2: cross product halves, one multiplier each
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			flags_s2 <= flags_s1;
			sa0_s2 <= SPW'(vert_x_s1)  * SPW'(prior_y_s1);
			sa1_s2 <= SPW'(prior_x_s1) * SPW'(vert_y_s1);
			sb0_s2 <= SPW'(start_x_s1) * SPW'(vert_y_s1);
			sb1_s2 <= SPW'(vert_x_s1)  * SPW'(start_y_s1);
			ta0_s2 <= TPW'(dvx) * TPW'(dpy);
			ta1_s2 <= TPW'(dpx) * TPW'(dvy);
			tb0_s2 <= TPW'(dsx) * TPW'(dvy);
			tb1_s2 <= TPW'(dvx) * TPW'(dsy);
		end
	end

	// Stage 3: edge terms; drop edge a on a first vertex, edge b unless closing
	assign shoe_a = TW'(sa0_s2) - TW'(sa1_s2);
	assign shoe_b = TW'(sb0_s2) - TW'(sb1_s2);
	assign tri_ad = TW'(ta0_s2) - TW'(ta1_s2);
	assign tri_bd = TW'(tb0_s2) - TW'(tb1_s2);

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			flags_s3  <= flags_s2;
			shoe_a_s3 <= flags_s2.first ? '0 : shoe_a;
			tri_a_s3  <= flags_s2.first ? '0 : (tri_ad[TW-1] ? -tri_ad : tri_ad);
			shoe_b_s3 <= flags_s2.close ? shoe_b : '0;
			tri_b_s3  <= flags_s2.close ? (tri_bd[TW-1] ? -tri_bd : tri_bd) : '0;
		end
	end

endmodule

### hdl/pzm_accum.sv
module pzm_accum #(
	parameter int CB = 24,
	parameter int AB = 58,
	parameter int TW = 2 * CB + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pzm_pkg::pzm_cfg_t    cfg,
	input  logic                 valid_s3,
	output logic                 up_ready,
	input  pzm_pkg::pzm_flags_t  flags_s3,
	input  logic signed [TW-1:0] shoe_a_s3,
	input  logic signed [TW-1:0] tri_a_s3,
	input  logic signed [TW-1:0] shoe_b_s3,
	input  logic signed [TW-1:0] tri_b_s3,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic                 m_res
);
	import pzm_pkg::*;

	localparam int EW = AB + 1;
	localparam logic signed [EW-1:0] HI_E = $signed({2'b00, {(AB-1){1'b1}}});
	localparam logic signed [EW-1:0] LO_E = $signed({2'b11, {(AB-1){1'b0}}});

	logic valid_s4, valid_s5, valid_s6;
	logic ready_s4, ready_s5, ready_s6;
	pzm_flags_t flags_s4, flags_s5, flags_s6;

	logic signed [EW-1:0] hma_s4, lma_s4, ab_s4, hb_s4, lb_s4, tt_s4;
	logic signed [EW-1:0] a_e, b_e;
	logic signed [AB-1:0] shoe_q, tri_q;
	logic signed [EW-1:0] d_s6;
	logic found_q;
	logic out_valid_q, out_res_q;

	logic signed [EW-1:0] shoe_base, shoe_sum, shoe_sat, shoe_next;
	logic signed [EW-1:0] tri_base, tri_sum, tri_next;
	logic over, under;
	logic signed [EW-1:0] lim;
	logic match, found_next, retire;

	// Handshake chain; only set-end items need the output register free
	assign ready_s6 = !valid_s6 || !flags_s6.eos || !out_valid_q || m_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign up_ready = ready_s4;
	assign retire   = valid_s6 && ready_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
			if (ready_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// Stage 4: bounds for the two-step saturating add of the shoelace terms
	assign a_e = EW'(shoe_a_s3);
	assign b_e = EW'(shoe_b_s3);

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			flags_s4 <= flags_s3;
			hma_s4   <= HI_E - a_e;
			lma_s4   <= LO_E - a_e;
			ab_s4    <= a_e + b_e;
			hb_s4    <= (b_e > 0) ? HI_E : HI_E + b_e;
			lb_s4    <= (b_e < 0) ? LO_E : LO_E + b_e;
			tt_s4    <= EW'(tri_a_s3) + EW'(tri_b_s3);
		end
	end

	// Stage 5: accumulate; first step clamps if sum plus edge a leaves range
	assign shoe_base = flags_s4.first ? '0 : EW'(shoe_q);
	assign over      = shoe_base > hma_s4;
	assign under     = shoe_base < lma_s4;
	assign shoe_sum  = shoe_base + ab_s4;
	assign shoe_sat  = (shoe_sum > HI_E) ? HI_E : ((shoe_sum < LO_E) ? LO_E : shoe_sum);
	assign shoe_next = over ? hb_s4 : (under ? lb_s4 : shoe_sat);

	// Triangle terms are never negative: one clamp at the top is exact
	assign tri_base = flags_s4.first ? '0 : EW'(tri_q);
	assign tri_sum  = tri_base + tt_s4;
	assign tri_next = (tri_sum > HI_E) ? HI_E : tri_sum;

	always_ff @(posedge clk) begin
		if (ready_s5) begin
			flags_s5 <= flags_s4;
			if (valid_s4) begin
				shoe_q <= shoe_next[AB-1:0];
				tri_q  <= tri_next[AB-1:0];
			end
		end
	end

	// Stage 6: triangle sum minus magnitude of the shoelace sum
	always_ff @(posedge clk) begin
		if (ready_s6) begin
			flags_s6 <= flags_s5;
			d_s6 <= shoe_q[AB-1] ? EW'(tri_q) + EW'(shoe_q) : EW'(tri_q) - EW'(shoe_q);
		end
	end

	// Match test against twice the tolerance, fold into the set flag
	assign lim        = $signed(EW'({cfg.area_tol, 1'b0}));
	assign match      = flags_s6.close && (d_s6 < lim) && (d_s6 > -lim);
	assign found_next = (flags_s6.set_start ? 1'b0 : found_q) || match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_res_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_ready) begin
				out_valid_q <= 1'b0;
			end
			if (retire) begin
				found_q <= found_next;
				if (flags_s6.eos) begin
					out_valid_q <= 1'b1;
					out_res_q   <= !cfg.zones_defined || found_next;
				end
			end
		end
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_res_q;

	// A result appears only from a retiring set-end item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s6 && flags_s6.eos))
		else $error("result raised without a set end");
	// An open first vertex of a set leaves no match behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(retire && flags_s6.set_start && !flags_s6.close) |=> !found_q)
		else $error("match flag not cleared at set start");

endmodule

### hdl/polygon_zone_membership.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: query_x, query_y, vertex_x, vertex_y;
//                                  tuser: end_of_polygon; tlast: end_of_set
// m_*      out  m_tvalid/m_tready  tdata: inside_res
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One vertex item is accepted per cycle unless the pipeline stalls; the rate
// is set by the saturating accumulator loop in stage 5.
// A result is registered at the output once its set-end item leaves stage 6.
// Reset clears control only; no clearing pass, the block is ready at once.
// A waiting result stalls only later set-end items at the last stage;
// other items keep flowing until the pipeline fills.
module polygon_zone_membership #(
	parameter int COORD_BITS   = 24,
	parameter int MAX_VERTICES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// query_x, query_y, vertex_x, vertex_y from bit 0 up, zero padded
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	// end_of_polygon
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// inside_res at bit 0, zero padded
	output logic [pzm_pkg::OUT_BITS-1:0]          m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pzm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [pzm_pkg::TOL_BITS-1:0]          cfg_data
);
	import pzm_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AB = 2 * CB + $clog2(MAX_VERTICES) + 4;
	localparam int TW = 2 * CB + 3;

	pzm_cfg_t cfg_q;

	logic signed [CB-1:0] query_x, query_y, vertex_x, vertex_y;

	logic       valid_s1, valid_s3;
	logic       ready_s2, ready_s4;
	pzm_flags_t flags_s1, flags_s3;
	logic signed [CB-1:0] vert_x_s1, vert_y_s1, prior_x_s1, prior_y_s1;
	logic signed [CB-1:0] start_x_s1, start_y_s1, point_x_s1, point_y_s1;
	logic signed [TW-1:0] shoe_a_s3, tri_a_s3, shoe_b_s3, tri_b_s3;
	logic       inside_res;

	// Unpack the input item
	assign query_x  = $signed(s_tdata[CB-1:0]);
	assign query_y  = $signed(s_tdata[2*CB-1:CB]);
	assign vertex_x = $signed(s_tdata[3*CB-1:2*CB]);
	assign vertex_y = $signed(s_tdata[4*CB-1:3*CB]);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_tol      <= AREA_TOL_RESET;
			cfg_q.zones_defined <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AREA_TOL: cfg_q.area_tol      <= cfg_data;
				REG_ZONES:    cfg_q.zones_defined <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pzm_front #(.CB(CB)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.query_x        (query_x),
		.query_y        (query_y),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.end_of_polygon (s_tuser),
		.end_of_set     (s_tlast),
		.down_ready     (ready_s2),
		.valid_s1       (valid_s1),
		.flags_s1       (flags_s1),
		.vert_x_s1      (vert_x_s1),
		.vert_y_s1      (vert_y_s1),
		.prior_x_s1     (prior_x_s1),
		.prior_y_s1     (prior_y_s1),
		.start_x_s1     (start_x_s1),
		.start_y_s1     (start_y_s1),
		.point_x_s1     (point_x_s1),
		.point_y_s1     (point_y_s1)
	);

	pzm_cross #(.CB(CB), .TW(TW)) u_cross (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.up_ready   (ready_s2),
		.flags_s1   (flags_s1),
		.vert_x_s1  (vert_x_s1),
		.vert_y_s1  (vert_y_s1),
		.prior_x_s1 (prior_x_s1),
		.prior_y_s1 (prior_y_s1),
		.start_x_s1 (start_x_s1),
		.start_y_s1 (start_y_s1),
		.point_x_s1 (point_x_s1),
		.point_y_s1 (point_y_s1),
		.down_ready (ready_s4),
		.valid_s3   (valid_s3),
		.flags_s3   (flags_s3),
		.shoe_a_s3  (shoe_a_s3),
		.tri_a_s3   (tri_a_s3),
		.shoe_b_s3  (shoe_b_s3),
		.tri_b_s3   (tri_b_s3)
	);

	pzm_accum #(.CB(CB), .AB(AB), .TW(TW)) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s3  (valid_s3),
		.up_ready  (ready_s4),
		.flags_s3  (flags_s3),
		.shoe_a_s3 (shoe_a_s3),
		.tri_a_s3  (tri_a_s3),
		.shoe_b_s3 (shoe_b_s3),
		.tri_b_s3  (tri_b_s3),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_res     (inside_res)
	);

	assign m_tdata = {{(OUT_BITS-1){1'b0}}, inside_res};

endmodule

### verif/pzm_zone_checker.sv
module pzm_zone_checker #(
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	// query_x, query_y, vertex_x, vertex_y from bit 0 up, zero padded
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	// end_of_polygon
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	// inside_res at bit 0, zero padded
	input  logic [pzm_pkg::OUT_BITS-1:0]          m_tdata,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [pzm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [pzm_pkg::TOL_BITS-1:0]          cfg_data,
	output int                                    errors,
	output int                                    outstanding,
	output int                                    checked
);
	import pzm_pkg::*;

	localparam int     DW         = ((4*COORD_BITS+7)/8)*8;
	localparam longint ACC_HI     = 64'sh01FF_FFFF_FFFF_FFFF;
	localparam longint ACC_LO     = -ACC_HI - 1;
	localparam int     MAX_REPORT = 20;
	localparam int     VQ_DEPTH   = 64;

	// Shadow configuration and accumulator state
	pzm_cfg_t             live_cfg;
	longint               point_x, point_y;
	longint               anchor_x, anchor_y;
	longint               trail_x, trail_y;
	longint               shoe_acc, fan_acc;
	bit                   hit_any, set_fresh, poly_fresh;
	// Verdicts in flight, oldest at ring_rd
	bit                   verdict_ring[VQ_DEPTH];
	int                   ring_wr, ring_rd;
	logic [OUT_BITS-1:0]  want_word;
	int                   reports;

	function automatic longint clip_acc(longint v);
		if (v > ACC_HI)
			return ACC_HI;
		if (v < ACC_LO)
			return ACC_LO;
		return v;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Add the shoelace and triangle terms of edge (a, b)
	function automatic void add_edge_terms(longint ax, longint ay, longint bx, longint by);
		longint shoe, fan;
		shoe = ax * by - bx * ay;
		fan  = mag((ax - point_x) * (by - point_y) - (bx - point_x) * (ay - point_y));
		shoe_acc = clip_acc(shoe_acc + shoe);
		fan_acc  = clip_acc(fan_acc + fan);
	endfunction

	// Advance the shadow state by one vertex item; queue a verdict at set end
	function automatic void fold_vertex(logic [DW-1:0] word, logic eop, logic eos);
		longint vx, vy, gap;
		vx = longint'($signed(word[2*COORD_BITS +: COORD_BITS]));
		vy = longint'($signed(word[3*COORD_BITS +: COORD_BITS]));
		if (set_fresh) begin
			point_x = longint'($signed(word[0 +: COORD_BITS]));
			point_y = longint'($signed(word[COORD_BITS +: COORD_BITS]));
			hit_any = 1'b0;
		end
		if (poly_fresh) begin
			anchor_x = vx;
			anchor_y = vy;
			shoe_acc = 0;
			fan_acc  = 0;
		end else begin
			add_edge_terms(vx, vy, trail_x, trail_y);
		end
		trail_x = vx;
		trail_y = vy;
		if (eop || eos) begin
			add_edge_terms(anchor_x, anchor_y, vx, vy);
			gap = mag(fan_acc - mag(shoe_acc));
			if (gap < 2 * longint'(live_cfg.area_tol))
				hit_any = 1'b1;
			poly_fresh = 1'b1;
		end else begin
			poly_fresh = 1'b0;
		end
		set_fresh = eos;
		if (eos) begin
			verdict_ring[ring_wr % VQ_DEPTH] = !live_cfg.zones_defined || hit_any;
			ring_wr++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_cfg.area_tol      = AREA_TOL_RESET;
			live_cfg.zones_defined = 1'b1;
			point_x    = 0;
			point_y    = 0;
			anchor_x   = 0;
			anchor_y   = 0;
			trail_x    = 0;
			trail_y    = 0;
			shoe_acc   = 0;
			fan_acc    = 0;
			hit_any    = 1'b0;
			set_fresh  = 1'b1;
			poly_fresh = 1'b1;
			ring_wr    = 0;
			ring_rd    = 0;
			errors      = 0;
			outstanding = 0;
			checked     = 0;
			reports     = 0;
		end else begin
			// Compare each result item against the oldest verdict
			if (m_tvalid && m_tready) begin
				if (ring_wr == ring_rd) begin
					errors++;
					if (reports < MAX_REPORT)
						$display("%0t: unexpected result item, expected none, got %0h",
							$time, m_tdata);
					reports++;
				end else begin
					want_word    = '0;
					want_word[0] = verdict_ring[ring_rd % VQ_DEPTH];
					ring_rd++;
					checked++;
					if (m_tdata !== want_word) begin
						errors++;
						if (reports < MAX_REPORT)
							$display("%0t: inside_res mismatch, expected %0h, got %0h",
								$time, want_word, m_tdata);
						reports++;
					end
				end
			end
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_AREA_TOL: live_cfg.area_tol = cfg_data;
					REG_ZONES:    live_cfg.zones_defined = cfg_data[0];
					default: ;
				endcase
			end
			// Fold each accepted vertex item
			if (s_tvalid && s_tready)
				fold_vertex(s_tdata, s_tuser, s_tlast);
			outstanding = ring_wr - ring_rd;
		end
	end

endmodule

### verif/tb_polygon_zone_membership.sv
module tb_polygon_zone_membership;
	import pzm_pkg::*;

	localparam int     CW         = 24;
	localparam int     DW         = ((4*CW+7)/8)*8;
	localparam longint CMAX       = 8388607;
	localparam longint CMIN       = -8388608;
	localparam int     IDLE_LIMIT = 1000;
	localparam int     SETTLE     = 12;
	localparam int     PHASES     = 8;
	localparam int     PHASE_ITEMS = 110;
	localparam int     POLY_MAX   = 1200;
	// How the closing vertex of a set treats its end_of_polygon flag
	localparam int     EOP_KEEP   = 0;
	localparam int     EOP_DROP   = 1;
	localparam int     EOP_RANDOM = 2;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid, s_tready;
	logic [DW-1:0]            s_tdata;
	logic                     s_tuser, s_tlast;
	logic                     m_tvalid, m_tready;
	logic [OUT_BITS-1:0]      m_tdata;
	logic                     cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [TOL_BITS-1:0]      cfg_data;

	int     errors, outstanding, checked;
	int     items_sent, sets_sent;
	int     idle_cycles = 0;
	bit     no_idle, set_head;
	longint poly_x[POLY_MAX], poly_y[POLY_MAX];
	int     poly_n;

	always #1 clk = ~clk;

	polygon_zone_membership #(
		.COORD_BITS(CW)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pzm_zone_checker #(
		.COORD_BITS(CW)
	) zone_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// Stop the run when no channel moves an item for too long
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Stall the result side in runs of random length
	initial begin
		int r, stall, run;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			r = $urandom_range(99);
			if (r < 45)
				stall = 0;
			else if (r < 80)
				stall = $urandom_range(3, 1);
			else if (r < 95)
				stall = $urandom_range(16, 4);
			else
				stall = $urandom_range(80, 30);
			run = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(8, 1);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(15, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic longint clampc(longint v);
		if (v > CMAX)
			return CMAX;
		if (v < CMIN)
			return CMIN;
		return v;
	endfunction

	// Random coordinate in [-span, span-1], or over the full field when span is 0
	function automatic longint rand_in(longint span);
		logic signed [CW-1:0] t;
		if (span == 0) begin
			t = CW'($urandom());
			return longint'(t);
		end
		return longint'($urandom_range(2*span-1)) - span;
	endfunction

	// Largest offset used to place vertices around the query point
	function automatic longint reach(longint span);
		return (span == 0) ? 64'sd4194304 : span;
	endfunction

	function automatic longint offs(longint w);
		return longint'($urandom_range(2*w)) - w;
	endfunction

	function automatic void put(longint x, longint y);
		if (poly_n < POLY_MAX) begin
			poly_x[poly_n] = clampc(x);
			poly_y[poly_n] = clampc(y);
			poly_n++;
		end
	endfunction

	// Offer one vertex item and hold it until accepted
	task automatic send_item(longint qx, longint qy, longint vx, longint vy, bit eop, bit eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vy[CW-1:0], vx[CW-1:0], qy[CW-1:0], qx[CW-1:0]};
		s_tuser  <= eop;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (eos)
			sets_sent++;
	endtask

	// Stream the queued polygon; the query point rides on the first item of a set
	task automatic emit_polygon(longint qx, longint qy, bit closes_set, int eop_mode);
		bit     eop, eos, last;
		longint nx, ny;
		for (int i = 0; i < poly_n; i++) begin
			last = (i == poly_n - 1);
			eos  = closes_set && last;
			eop  = last;
			if (eos && (eop_mode == EOP_DROP || (eop_mode == EOP_RANDOM && $urandom_range(3) == 0)))
				eop = 1'b0;
			if (set_head) begin
				nx = qx;
				ny = qy;
			end else begin
				nx = rand_in(0);
				ny = rand_in(0);
			end
			set_head = 1'b0;
			send_item(nx, ny, poly_x[i], poly_y[i], eop, eos);
		end
		poly_n = 0;
	endtask

	// Build a rectangle, either around the query point or anywhere nearby
	task automatic build_rect(longint qx, longint qy, longint span, bit around);
		longint w, x0, x1, y0, y1;
		longint cx[4], cy[4];
		int     rot;
		bit     rev;
		w = reach(span);
		if (around) begin
			x0 = ($urandom_range(9) == 0) ? qx : qx - 1 - $urandom_range(w);
			x1 = qx + 1 + $urandom_range(w);
			y0 = qy - 1 - $urandom_range(w);
			y1 = ($urandom_range(9) == 0) ? qy : qy + 1 + $urandom_range(w);
		end else begin
			x0 = qx + offs(w);
			y0 = qy + offs(w);
			x1 = x0 + 1 + $urandom_range(w);
			y1 = y0 + 1 + $urandom_range(w);
		end
		cx = '{x0, x1, x1, x0};
		cy = '{y0, y0, y1, y1};
		rot = $urandom_range(3);
		rev = 1'($urandom_range(1));
		for (int i = 0; i < 4; i++) begin
			if (rev)
				put(cx[(rot - i) & 3], cy[(rot - i) & 3]);
			else
				put(cx[(rot + i) & 3], cy[(rot + i) & 3]);
		end
	endtask

	// One well-formed query set of one to four polygons
	task automatic random_set();
		longint span, w, qx, qy, d;
		int     r, npoly, kind, n;
		r = $urandom_range(99);
		span = (r < 70) ? 1024 : (r < 85) ? 65536 : 0;
		w = reach(span);
		qx = rand_in(span);
		qy = rand_in(span);
		no_idle = ($urandom_range(4) == 0);
		npoly = ($urandom_range(2) == 0) ? 1 : $urandom_range(4, 1);
		set_head = 1'b1;
		for (int p = 0; p < npoly; p++) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				build_rect(qx, qy, span, 1'($urandom_range(1)));
			end else if (kind < 70) begin
				if ($urandom_range(1)) begin
					d = 1 + $urandom_range(w);
					put(qx - 1 - $urandom_range(w), qy - d);
					put(qx + 1 + $urandom_range(w), qy - d);
					put(qx, qy + 1 + $urandom_range(w));
				end else begin
					repeat (3) put(qx + offs(w), qy + offs(w));
				end
			end else if (kind < 85) begin
				n = $urandom_range(10, 3);
				repeat (n) put(qx + offs(w), qy + offs(w));
			end else if (kind < 98) begin
				if ($urandom_range(1)) begin
					put(qx + offs(w), qy + offs(w));
				end else if ($urandom_range(1)) begin
					d = offs(w);
					put(qx - d, qy + d / 2);
					put(qx + d, qy - d / 2);
				end else begin
					repeat (2) put(qx + offs(w), qy + offs(w));
				end
			end else begin
				n = $urandom_range(300, 64);
				repeat (n) put(rand_in(0), rand_in(0));
			end
			emit_polygon(qx, qy, p == npoly - 1, EOP_RANDOM);
		end
	endtask

	// Arbitrary flags and coordinates; the last item closes the set
	task automatic noise_run();
		int n;
		n = $urandom_range(12, 1);
		no_idle = 1'b0;
		for (int i = 0; i < n; i++)
			send_item(rand_in(0), rand_in(0), rand_in(0), rand_in(0),
				$urandom_range(2) == 0, (i == n - 1) || ($urandom_range(5) == 0));
	endtask

	// Circle the full-scale square many times so both sums clip
	task automatic wound_polygon();
		longint cx[4], cy[4];
		bit     rev;
		cx = '{CMAX, CMIN, CMIN, CMAX};
		cy = '{CMAX, CMAX, CMIN, CMIN};
		rev = 1'($urandom_range(1));
		for (int i = 0; i < 1100; i++)
			put(cx[rev ? (3 - (i & 3)) : (i & 3)], cy[rev ? (3 - (i & 3)) : (i & 3)]);
		no_idle = 1'b1;
		set_head = 1'b1;
		emit_polygon(rand_in(0), rand_in(0), 1'b1, EOP_KEEP);
	endtask

	// Hold the sender until every verdict is back and the pipeline is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TOL_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		longint             phase_start;
		logic [TOL_BITS-1:0] tol;
		bit                 zones;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_AREA_TOL;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		items_sent  = 0;
		sets_sent   = 0;
		poly_n      = 0;
		no_idle     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets under the reset configuration
		// point inside a square of side 1024
		set_head = 1'b1;
		put(0, 0); put(1024, 0); put(1024, 1024); put(0, 1024);
		emit_polygon(512, 512, 1'b1, EOP_KEEP);
		// point outside the same square
		set_head = 1'b1;
		put(0, 0); put(1024, 0); put(1024, 1024); put(0, 1024);
		emit_polygon(2048, 512, 1'b1, EOP_KEEP);
		// single-vertex polygon at the field extremes
		set_head = 1'b1;
		put(CMAX, CMIN);
		emit_polygon(CMIN, CMAX, 1'b1, EOP_KEEP);
		// two-vertex polygon through the point
		set_head = 1'b1;
		put(-512, -512); put(512, 512);
		emit_polygon(0, 0, 1'b1, EOP_KEEP);
		// set end closes a triangle without its polygon flag
		set_head = 1'b1;
		put(0, 0); put(2048, 0); put(0, 2048);
		emit_polygon(256, 256, 1'b1, EOP_DROP);
		// off-line segment, then a single vertex that matches
		set_head = 1'b1;
		put(0, 0); put(1024, 0);
		emit_polygon(CMIN, CMIN, 1'b0, EOP_KEEP);
		put(CMIN, CMAX);
		emit_polygon(CMIN, CMIN, 1'b1, EOP_KEEP);

		// Random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin tol = '0; zones = 1'b1; end
				1: begin tol = '1; zones = 1'b1; end
				2: begin tol = TOL_BITS'($urandom_range(4000)); zones = 1'b0; end
				3: begin tol = AREA_TOL_RESET; zones = 1'b1; end
				4: begin tol = TOL_BITS'(1); zones = 1'b1; end
				5: begin tol = TOL_BITS'($urandom_range(1048575)); zones = 1'b1; end
				6: begin tol = TOL_BITS'($urandom_range(300)); zones = 1'b1; end
				default: begin tol = TOL_BITS'($urandom_range(200)); zones = 1'b1; end
			endcase
			write_reg(REG_AREA_TOL, tol);
			write_reg(REG_ZONES, {{(TOL_BITS-1){1'b0}}, zones});
			phase_start = items_sent;
			if (phase == 3)
				wound_polygon();
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(9) == 0)
					noise_run();
				else
					random_set();
				if ($urandom_range(39) == 0)
					drain();
			end
		end
		drain();

		$display("Drove %0d vertex items in %0d query sets over %0d register settings.",
			items_sent, sets_sent, PHASES + 1);
		$display("Compared %0d zone verdicts, including clipped sums and degenerate polygons.",
			checked);
		if (errors == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/pzm_pkg.sv
hdl/pzm_front.sv
hdl/pzm_cross.sv
hdl/pzm_accum.sv
hdl/polygon_zone_membership.sv
verif/pzm_zone_checker.sv
verif/tb_polygon_zone_membership.sv
